[src/lsu_pkg.sv]
`default_nettype none

package lsu_pkg;

    localparam int DATA_W      = 16;
    localparam int CELL_W      = 24;
    localparam int MAX_UNITS   = 16;
    localparam int MAX_INPUT   = 32;
    localparam int ROW_STRIDE  = 4 * MAX_UNITS;
    localparam int U_BASE      = MAX_INPUT * ROW_STRIDE;
    localparam int B_BASE      = U_BASE + MAX_UNITS * ROW_STRIDE;
    localparam int PMEM_DEPTH  = B_BASE + ROW_STRIDE;
    localparam int PMEM_AW     = 12;
    localparam int Q_ONE       = 4096;
    localparam int SAT_MAG     = 8 * Q_ONE;
    localparam int SIG_IN_W    = 27;
    localparam int SIG_OUT_W   = 13;
    localparam int CELL_MAX    = 8388607;
    localparam int CELL_MIN    = -8388608;

    localparam logic [1:0] CMD_PARAM = 2'd0;
    localparam logic [1:0] CMD_ELEM  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] CFG_INPUT_SIZE = 2'd0;
    localparam logic [1:0] CFG_UNIT_COUNT = 2'd1;
    localparam logic [1:0] CFG_EMIT_EVERY = 2'd2;

    function automatic logic [SIG_OUT_W-1:0] sig_tab(input logic [5:0] idx);
        logic [SIG_OUT_W-1:0] v;
        case (idx)
            6'd0:  v = 13'd2048;
            6'd1:  v = 13'd2303;
            6'd2:  v = 13'd2550;
            6'd3:  v = 13'd2782;
            6'd4:  v = 13'd2994;
            6'd5:  v = 13'd3184;
            6'd6:  v = 13'd3349;
            6'd7:  v = 13'd3490;
            6'd8:  v = 13'd3608;
            6'd9:  v = 13'd3705;
            6'd10: v = 13'd3785;
            6'd11: v = 13'd3850;
            6'd12: v = 13'd3902;
            6'd13: v = 13'd3943;
            6'd14: v = 13'd3976;
            6'd15: v = 13'd4002;
            6'd16: v = 13'd4022;
            6'd17: v = 13'd4038;
            6'd18: v = 13'd4051;
            6'd19: v = 13'd4061;
            6'd20: v = 13'd4069;
            6'd21: v = 13'd4075;
            6'd22: v = 13'd4079;
            6'd23: v = 13'd4083;
            6'd24: v = 13'd4086;
            6'd25: v = 13'd4088;
            6'd26: v = 13'd4090;
            6'd27: v = 13'd4091;
            6'd28: v = 13'd4092;
            6'd29: v = 13'd4093;
            6'd30: v = 13'd4094;
            6'd31: v = 13'd4094;
            default: v = 13'd4096;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[src/lsu_sigmoid.sv]
`default_nettype none

module lsu_sigmoid (
    input  wire logic signed [lsu_pkg::SIG_IN_W-1:0]  i_x,
    output logic             [lsu_pkg::SIG_OUT_W-1:0] o_s
);
    import lsu_pkg::*;

    logic [SIG_IN_W-1:0]  mag;
    logic [4:0]           idx;
    logic [9:0]           frac;
    logic [SIG_OUT_W-1:0] lo;
    logic [SIG_OUT_W-1:0] hi;
    logic [8:0]           diff;
    logic [18:0]          prod;
    logic [8:0]           interp;
    logic [SIG_OUT_W-1:0] s;

    always_comb begin
        mag    = i_x[SIG_IN_W-1] ? SIG_IN_W'(-i_x) : SIG_IN_W'(i_x);
        idx    = mag[14:10];
        frac   = mag[9:0];
        lo     = sig_tab({1'b0, idx});
        hi     = sig_tab({1'b0, idx} + 6'd1);
        diff   = 9'(hi - lo);
        prod   = 19'(diff) * 19'(frac);
        interp = 9'((prod + 19'd512) >> 10);
        s      = (mag >= SIG_IN_W'(SAT_MAG)) ? SIG_OUT_W'(Q_ONE) : lo + SIG_OUT_W'(interp);
        o_s    = i_x[SIG_IN_W-1] ? SIG_OUT_W'(Q_ONE) - s : s;
    end

endmodule

`default_nettype wire

[src/lstm_layer_step_unit.sv]
// Step: a timestep's last element starts the work for U units over N buffered elements,
// one parameter memory read per cycle while accumulating, then U beats out if emitting.
// Throughput: one item per cycle for parameter, element and clear commands while idle;
// the single multiply-accumulate pipeline on the parameter memory port sets step time.
// Reset: synchronous, active low; hidden and cell state zero, registers 27, 16, 1.
`default_nettype none

module lstm_layer_step_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [1:0]                  i_command,
    input  wire logic [11:0]                 i_address,
    input  wire logic signed [lsu_pkg::DATA_W-1:0] i_value,
    input  wire logic                        i_last_element,
    input  wire logic                        i_final_step,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [3:0]                       o_unit_index,
    output logic signed [lsu_pkg::DATA_W-1:0] o_hidden_value,
    output logic                             o_last,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [1:0]                  i_cfg_index,
    input  wire logic [5:0]                  i_cfg_data
);
    import lsu_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MAC, S_DRAIN, S_ACT, S_EMIT} t_state;
    typedef enum logic [1:0] {K_BIAS, K_INPUT, K_HIDDEN} t_kind;

    t_state r_state;

    logic [5:0] r_input_size;
    logic [4:0] r_unit_count;
    logic       r_emit_every;

    logic signed [DATA_W-1:0] r_pmem [PMEM_DEPTH];
    logic signed [DATA_W-1:0] r_prd;
    logic signed [DATA_W-1:0] r_buf [MAX_INPUT];
    logic signed [DATA_W-1:0] r_brd;

    logic signed [DATA_W-1:0] r_h [2][MAX_UNITS];
    logic signed [CELL_W-1:0] r_c [MAX_UNITS];
    logic                     r_bank;

    logic [5:0] r_el_count;
    logic [5:0] r_nx;
    logic       r_emit;
    logic [3:0] r_j;
    logic [1:0] r_g;
    logic [5:0] r_t;
    logic [3:0] r_step;
    logic [4:0] r_eidx;

    logic                     r_s1_v;
    t_kind                    r_s1_kind;
    logic                     r_s1_first;
    logic                     r_s1_last;
    logic [1:0]               r_s1_g;
    logic signed [DATA_W-1:0] r_s1_h;
    logic                     r_s2_v;
    logic                     r_s2_first;
    logic                     r_s2_last;
    logic [1:0]               r_s2_g;
    logic signed [31:0]       r_s2_p;
    logic signed [36:0]       r_acc;
    logic signed [24:0]       r_z [4];

    logic signed [13:0] r_ig;
    logic signed [13:0] r_fg;
    logic signed [13:0] r_gg;
    logic signed [13:0] r_og;
    logic signed [13:0] r_tc;
    logic signed [37:0] r_pf;
    logic signed [27:0] r_pi;
    logic signed [27:0] r_ph;
    logic signed [CELL_W-1:0] r_cn;

    logic [5:0]               eff_n;
    logic [4:0]               eff_u;
    logic [5:0]               col;
    logic [4:0]               k_in;
    logic [3:0]               k_hid;
    t_kind                    kind;
    logic [PMEM_AW-1:0]       rd_addr;
    logic                     term_last;
    logic [3:0]               h_rd_idx;
    logic signed [DATA_W-1:0] h_rd;
    logic signed [DATA_W-1:0] mac_a;
    logic signed [36:0]       acc_sum;
    logic signed [SIG_IN_W-1:0] sig_x;
    logic [SIG_OUT_W-1:0]     sig_s;
    logic signed [13:0]       sig_q;
    logic signed [14:0]       th_w;
    logic signed [38:0]       c_sum;
    logic signed [38:0]       c_rnd;
    logic signed [CELL_W-1:0] c_new;
    logic signed [27:0]       h_sum;
    logic signed [27:0]       h_rnd;
    logic signed [DATA_W-1:0] h_new;
    logic                     in_acc;
    logic                     out_free;

    lsu_sigmoid u_sigmoid (
        .i_x (sig_x),
        .o_s (sig_s)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !o_out_valid || !i_out_stall;

    always_comb begin
        if (r_input_size == 6'd0) begin
            eff_n = 6'd1;
        end else if (r_input_size > 6'(MAX_INPUT)) begin
            eff_n = 6'(MAX_INPUT);
        end else begin
            eff_n = r_input_size;
        end
        if (r_unit_count == 5'd0) begin
            eff_u = 5'd1;
        end else if (r_unit_count > 5'(MAX_UNITS)) begin
            eff_u = 5'(MAX_UNITS);
        end else begin
            eff_u = r_unit_count;
        end

        col       = 6'(r_g) * 6'(eff_u) + 6'(r_j);
        k_in      = 5'(r_t - 6'd1);
        k_hid     = 4'(r_t - 6'd1 - r_nx);
        term_last = (r_t == r_nx + 6'(eff_u));
        if (r_t == 6'd0) begin
            kind    = K_BIAS;
            rd_addr = PMEM_AW'(B_BASE) + PMEM_AW'(col);
        end else if (r_t <= r_nx) begin
            kind    = K_INPUT;
            rd_addr = PMEM_AW'({k_in, col});
        end else begin
            kind    = K_HIDDEN;
            rd_addr = PMEM_AW'(U_BASE) + PMEM_AW'({k_hid, col});
        end

        h_rd_idx = (r_state == S_EMIT) ? r_eidx[3:0] : k_hid;
        h_rd     = r_h[(r_state == S_EMIT) ? r_bank : r_bank][h_rd_idx];

        case (r_s1_kind)
            K_BIAS:   mac_a = DATA_W'(Q_ONE);
            K_INPUT:  mac_a = r_brd;
            K_HIDDEN: mac_a = r_s1_h;
            default:  mac_a = '0;
        endcase
        acc_sum = r_s2_first ? (37'(r_s2_p) | 37'sd2048) : r_acc + 37'(r_s2_p);

        case (r_step)
            4'd0:    sig_x = SIG_IN_W'(r_z[0]);
            4'd1:    sig_x = SIG_IN_W'(r_z[1]);
            4'd2:    sig_x = SIG_IN_W'(signed'({r_z[2], 1'b0}));
            4'd3:    sig_x = SIG_IN_W'(r_z[3]);
            4'd7:    sig_x = SIG_IN_W'(signed'({r_cn, 1'b0}));
            default: sig_x = '0;
        endcase
        sig_q = signed'({1'b0, sig_s});
        th_w  = signed'({1'b0, sig_s, 1'b0}) - 15'sd4096;

        c_sum = 39'(r_pf) + 39'(r_pi) + 39'sd2048;
        c_rnd = c_sum >>> 12;
        if (c_rnd > 39'(CELL_MAX)) begin
            c_new = CELL_W'(CELL_MAX);
        end else if (c_rnd < 39'(CELL_MIN)) begin
            c_new = CELL_W'(CELL_MIN);
        end else begin
            c_new = CELL_W'(c_rnd);
        end

        h_sum = r_ph + 28'sd2048;
        h_rnd = h_sum >>> 12;
        if (h_rnd > 28'sd32767) begin
            h_new = 16'sh7fff;
        end else if (h_rnd < -28'sd32768) begin
            h_new = 16'sh8000;
        end else begin
            h_new = DATA_W'(h_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_command == CMD_PARAM && i_address < PMEM_AW'(PMEM_DEPTH)) begin
            r_pmem[i_address] <= i_value;
        end
        r_prd <= r_pmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_command == CMD_ELEM && r_el_count < eff_n) begin
            r_buf[r_el_count[4:0]] <= i_value;
        end
        r_brd <= r_buf[k_in];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_input_size <= 6'd27;
            r_unit_count <= 5'd16;
            r_emit_every <= 1'b1;
            r_bank       <= 1'b0;
            r_el_count   <= '0;
            r_s1_v       <= 1'b0;
            r_s2_v       <= 1'b0;
            o_out_valid  <= 1'b0;
            for (int b = 0; b < 2; b++) begin
                for (int u = 0; u < MAX_UNITS; u++) begin
                    r_h[b][u] <= '0;
                end
            end
            for (int u = 0; u < MAX_UNITS; u++) begin
                r_c[u] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INPUT_SIZE: r_input_size <= i_cfg_data;
                    CFG_UNIT_COUNT: r_unit_count <= i_cfg_data[4:0];
                    CFG_EMIT_EVERY: r_emit_every <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // multiply-accumulate pipeline
            r_s1_v     <= (r_state == S_MAC);
            r_s2_v     <= r_s1_v;
            r_s2_first <= r_s1_first;
            r_s2_last  <= r_s1_last;
            r_s2_g     <= r_s1_g;
            r_s2_p     <= mac_a * r_prd;
            if (r_s2_v) begin
                r_acc <= acc_sum;
                if (r_s2_last) begin
                    r_z[r_s2_g] <= acc_sum[36:12];
                end
            end

            if (r_state == S_EMIT && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_command)
                            CMD_CLEAR: begin
                                r_el_count <= '0;
                                for (int b = 0; b < 2; b++) begin
                                    for (int u = 0; u < MAX_UNITS; u++) begin
                                        r_h[b][u] <= '0;
                                    end
                                end
                                for (int u = 0; u < MAX_UNITS; u++) begin
                                    r_c[u] <= '0;
                                end
                            end
                            CMD_ELEM: begin
                                if (i_last_element) begin
                                    r_nx       <= (r_el_count < eff_n) ? r_el_count + 6'd1 : eff_n;
                                    r_el_count <= '0;
                                    r_emit     <= r_emit_every || i_final_step;
                                    r_j        <= '0;
                                    r_g        <= '0;
                                    r_t        <= '0;
                                    r_state    <= S_MAC;
                                end else if (r_el_count < eff_n) begin
                                    r_el_count <= r_el_count + 6'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MAC: begin
                    r_s1_kind  <= kind;
                    r_s1_first <= (r_t == 6'd0);
                    r_s1_last  <= term_last;
                    r_s1_g     <= r_g;
                    r_s1_h     <= h_rd;
                    if (term_last) begin
                        r_t <= '0;
                        r_g <= r_g + 2'd1;
                        if (r_g == 2'd3) begin
                            r_state <= S_DRAIN;
                        end
                    end else begin
                        r_t <= r_t + 6'd1;
                    end
                end
                S_DRAIN: begin
                    if (!r_s1_v && !r_s2_v) begin
                        r_step  <= '0;
                        r_state <= S_ACT;
                    end
                end
                S_ACT: begin
                    r_step <= r_step + 4'd1;
                    case (r_step)
                        4'd0: r_ig <= sig_q;
                        4'd1: r_fg <= sig_q;
                        4'd2: r_gg <= 14'(th_w);
                        4'd3: r_og <= sig_q;
                        4'd4: r_pf <= 38'(r_fg) * 38'(r_c[r_j]);
                        4'd5: r_pi <= 28'(r_ig) * 28'(r_gg);
                        4'd6: begin
                            r_c[r_j] <= c_new;
                            r_cn     <= c_new;
                        end
                        4'd7: r_tc <= 14'(th_w);
                        4'd8: r_ph <= 28'(r_og) * 28'(r_tc);
                        4'd9: begin
                            r_h[!r_bank][r_j] <= h_new;
                            if (5'(r_j) == eff_u - 5'd1) begin
                                // carry the units outside this step into the new bank
                                for (int u = 0; u < MAX_UNITS; u++) begin
                                    if (5'(u) >= eff_u) begin
                                        r_h[!r_bank][u] <= r_h[r_bank][u];
                                    end
                                end
                                r_bank  <= !r_bank;
                                r_eidx  <= '0;
                                r_state <= r_emit ? S_EMIT : S_IDLE;
                            end else begin
                                r_j     <= r_j + 4'd1;
                                r_g     <= '0;
                                r_t     <= '0;
                                r_state <= S_MAC;
                            end
                        end
                        default: ;
                    endcase
                end
                S_EMIT: begin
                    if (out_free) begin
                        o_unit_index   <= r_eidx[3:0];
                        o_hidden_value <= h_rd;
                        o_last         <= (r_eidx == eff_u - 5'd1);
                        r_eidx         <= r_eidx + 5'd1;
                        if (r_eidx == eff_u - 5'd1) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_el_count <= 6'(MAX_INPUT))
        else $error("element count beyond buffer depth");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_last |=> !o_out_valid)
        else $error("beat after last of vector");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (5'(o_unit_index) < eff_u))
        else $error("unit index beyond unit count");

    a_no_mac_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_EMIT) |-> !r_s1_v && !r_s2_v)
        else $error("accumulate pipeline busy outside step");

endmodule

`default_nettype wire
